// ===== sv/multilevel_queue_scheduler_core_defines.svh =====
// assertion macros for the scheduler
`ifndef MULTILEVEL_QUEUE_SCHEDULER_CORE_DEFINES_SVH
`define MULTILEVEL_QUEUE_SCHEDULER_CORE_DEFINES_SVH

// implication checked every cycle outside reset
`define MQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MQS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mqs_pkg.sv =====
// ----------------------------------------------------------------------------
// mqs_pkg
// shared types and codes of the multilevel queue scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mqs_pkg;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_REJ_FULL  = 3'd1;
  localparam logic [2:0] ST_REJ_ZERO  = 3'd2;
  localparam logic [2:0] ST_TICK_IDLE = 3'd3;
  localparam logic [2:0] ST_TICK_RAN  = 3'd4;

  localparam logic ACT_ARRIVAL = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  localparam logic [7:0] QUANTUM_RESET = 8'd2;
  localparam int unsigned REG_QUANTUM = 0;

  // one entry of the priority queue
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  level;
    logic [15:0] remaining;
  } prio_entry_t;

  // one entry of the round-robin queue
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] remaining;
  } rr_entry_t;

endpackage

// ===== sv/mqs_if.sv =====
// ----------------------------------------------------------------------------
// mqs_if
// valid/ready channel carrying one W-bit payload vector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mqs_if #(parameter int unsigned W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/multilevel_queue_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// multilevel_queue_scheduler_core
// two-level job scheduler: sorted priority queue over a round-robin queue
// ----------------------------------------------------------------------------
// channel   dir  payload (msb..lsb)
// in        in   action, proc_id[7:0], burst[15:0], priority_req[7:0]
// out       out  status[2:0], ran_id, from_second_level, finished,
//                prio_waiting[4:0], rr_waiting[4:0]
// cfg       in   apb, register 0 = rr_quantum at byte 0
//
// an arrival walks the priority queue from its tail, one ram read and one
// write per entry; a tick that pops the priority head shifts each entry
// left behind it down by one slot through the priority ram. one
// transaction is worked at a time.
// reset is synchronous; a result waiting in the output register holds off
// intake until the sink takes it.
`timescale 1ns / 1ps
`include "multilevel_queue_scheduler_core_defines.svh"
module multilevel_queue_scheduler_core
  import mqs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mqs_if.sink         in_ch,
  mqs_if.source       out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_INS_RD  = 10'b0000000010,
    S_INS_CHK = 10'b0000000100,
    S_HEAD_RD = 10'b0000001000,
    S_HEAD_CK = 10'b0000010000,
    S_SH_RD   = 10'b0000100000,
    S_SH_WR   = 10'b0001000000,
    S_RR_RD   = 10'b0010000000,
    S_RR_CK   = 10'b0100000000,
    S_RUN     = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0] quantum_r;
  logic [CW-1:0] prio_count_r, rr_count_r;
  logic [AW-1:0] rr_head_r;
  logic [7:0] cur_id_r, cur_level_r, quantum_left_r;
  logic [15:0] cur_rem_r;
  logic cur_from_rr_r, busy_r;
  logic [CW-1:0] idx_r;
  logic [7:0] in_id_r, in_prio_r;
  logic [15:0] in_burst_r;
  logic out_valid_r;
  logic [22:0] out_data_r;

  // priority ram
  logic p_we;
  logic [AW-1:0] p_waddr, p_raddr;
  prio_entry_t p_wdata, p_rdata;
  // round-robin ram
  logic r_we;
  logic [AW-1:0] r_waddr, r_raddr;
  rr_entry_t r_wdata, r_rdata;

  mqs_ram #(.WIDTH($bits(prio_entry_t)), .DEPTH(QUEUE_DEPTH)) u_prio_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata));
  mqs_ram #(.WIDTH($bits(rr_entry_t)), .DEPTH(QUEUE_DEPTH)) u_rr_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata));

  // apb
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? {24'd0, quantum_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
    end else if (cfg_wr && cfg_paddr == 1'(REG_QUANTUM)) begin
      quantum_r <= cfg_pwdata[7:0];
    end
  end

  assign in_ch.ready = (state_r == S_IDLE) && !(out_valid_r && !out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_data_r;

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;

  // working copies of control state
  logic [CW-1:0] prio_count_nxt, rr_count_nxt, idx_nxt;
  logic [AW-1:0] rr_head_nxt;
  logic [7:0] cur_id_nxt, cur_level_nxt, quantum_left_nxt, in_id_nxt, in_prio_nxt;
  logic [15:0] cur_rem_nxt, in_burst_nxt, rem_dec;
  logic cur_from_rr_nxt, busy_nxt, out_valid_nxt, do_emit;
  logic [2:0] em_status;
  logic [7:0] em_id;
  logic em_from2, em_fin;
  logic [7:0] q_eff, ql_dec;
  logic [AW-1:0] rr_tail;
  logic [CW:0] tail_sum;

  assign q_eff = (quantum_r == 8'd0) ? 8'd1 : quantum_r;
  // wrap the tail slot with a compare and subtract
  assign tail_sum = {1'b0, CW'(rr_head_r)} + {1'b0, rr_count_r};
  assign rr_tail = (tail_sum >= {1'b0, DEPTH_C}) ? AW'(tail_sum - {1'b0, DEPTH_C})
                                                 : AW'(tail_sum);

  always_comb begin
    state_nxt = state_r;
    prio_count_nxt = prio_count_r;
    rr_count_nxt = rr_count_r;
    rr_head_nxt = rr_head_r;
    cur_id_nxt = cur_id_r;
    cur_level_nxt = cur_level_r;
    cur_rem_nxt = cur_rem_r;
    cur_from_rr_nxt = cur_from_rr_r;
    quantum_left_nxt = quantum_left_r;
    busy_nxt = busy_r;
    idx_nxt = idx_r;
    in_id_nxt = in_id_r;
    in_prio_nxt = in_prio_r;
    in_burst_nxt = in_burst_r;
    do_emit = 1'b0;
    em_status = ST_ACCEPTED;
    em_id = 8'd0;
    em_from2 = 1'b0;
    em_fin = 1'b0;
    p_we = 1'b0;
    p_waddr = '0;
    p_wdata = p_rdata;
    p_raddr = '0;
    r_we = 1'b0;
    r_waddr = rr_tail;
    r_wdata = '{id: cur_id_r, remaining: cur_rem_r};
    r_raddr = rr_head_r;
    rem_dec = cur_rem_r - 16'd1;
    ql_dec = quantum_left_r - 8'd1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          in_id_nxt = in_ch.data[31:24];
          in_burst_nxt = in_ch.data[23:8];
          in_prio_nxt = in_ch.data[7:0];
          if (in_ch.data[32] == ACT_ARRIVAL) begin
            if (in_ch.data[23:8] == 16'd0) begin
              do_emit = 1'b1;
              em_status = ST_REJ_ZERO;
            end else if (prio_count_r + rr_count_r + CW'(busy_r) >= DEPTH_C) begin
              do_emit = 1'b1;
              em_status = ST_REJ_FULL;
            end else begin
              idx_nxt = prio_count_r;
              state_nxt = S_INS_RD;
            end
          end else if (!busy_r) begin
            if (prio_count_r != '0) begin
              state_nxt = S_HEAD_RD;
            end else if (rr_count_r != '0) begin
              state_nxt = S_RR_RD;
            end else begin
              do_emit = 1'b1;
              em_status = ST_TICK_IDLE;
            end
          end else if (prio_count_r != '0) begin
            state_nxt = S_HEAD_RD;
          end else begin
            state_nxt = S_RUN;
          end
        end
      end
      // walk from the tail: read entry idx-1, shift it up if new one is smaller
      S_INS_RD: begin
        if (idx_r == '0) begin
          p_we = 1'b1;
          p_waddr = '0;
          p_wdata = '{id: in_id_r, level: in_prio_r, remaining: in_burst_r};
          prio_count_nxt = prio_count_r + 1'b1;
          do_emit = 1'b1;
          em_status = ST_ACCEPTED;
          state_nxt = S_IDLE;
        end else begin
          p_raddr = AW'(idx_r - 1'b1);
          state_nxt = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        p_we = 1'b1;
        p_waddr = AW'(idx_r);
        if (in_prio_r < p_rdata.level) begin
          p_wdata = p_rdata;
          idx_nxt = idx_r - 1'b1;
          state_nxt = S_INS_RD;
        end else begin
          p_wdata = '{id: in_id_r, level: in_prio_r, remaining: in_burst_r};
          prio_count_nxt = prio_count_r + 1'b1;
          do_emit = 1'b1;
          em_status = ST_ACCEPTED;
          state_nxt = S_IDLE;
        end
      end
      S_HEAD_RD: begin
        p_raddr = '0;
        state_nxt = S_HEAD_CK;
      end
      S_HEAD_CK: begin
        if (!busy_r || cur_from_rr_r || p_rdata.level < cur_level_r) begin
          if (busy_r) begin
            r_we = 1'b1;
            rr_count_nxt = rr_count_r + 1'b1;
          end
          cur_id_nxt = p_rdata.id;
          cur_level_nxt = p_rdata.level;
          cur_rem_nxt = p_rdata.remaining;
          cur_from_rr_nxt = 1'b0;
          busy_nxt = 1'b1;
          prio_count_nxt = prio_count_r - 1'b1;
          idx_nxt = '0;
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_RUN;
        end
      end
      // shift entries down: entry i <= entry i+1
      S_SH_RD: begin
        if (idx_r + 1'b1 >= prio_count_r + 1'b1) begin
          state_nxt = S_RUN;
        end else begin
          p_raddr = AW'(idx_r + 1'b1);
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        p_we = 1'b1;
        p_waddr = AW'(idx_r);
        p_wdata = p_rdata;
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_SH_RD;
      end
      S_RR_RD: begin
        r_raddr = rr_head_r;
        state_nxt = S_RR_CK;
      end
      S_RR_CK: begin
        cur_id_nxt = r_rdata.id;
        cur_rem_nxt = r_rdata.remaining;
        cur_level_nxt = 8'd0;
        cur_from_rr_nxt = 1'b1;
        quantum_left_nxt = q_eff;
        rr_head_nxt = (rr_head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rr_head_r + 1'b1;
        rr_count_nxt = rr_count_r - 1'b1;
        busy_nxt = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        do_emit = 1'b1;
        em_status = ST_TICK_RAN;
        em_id = cur_id_r;
        em_from2 = cur_from_rr_r;
        cur_rem_nxt = rem_dec;
        if (cur_from_rr_r) begin
          quantum_left_nxt = ql_dec;
        end
        if (rem_dec == 16'd0) begin
          em_fin = 1'b1;
          busy_nxt = 1'b0;
        end else if (cur_from_rr_r && ql_dec == 8'd0) begin
          busy_nxt = 1'b0;
          r_we = 1'b1;
          r_wdata = '{id: cur_id_r, remaining: rem_dec};
          rr_count_nxt = rr_count_r + 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = do_emit || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      prio_count_r <= '0;
      rr_count_r <= '0;
      rr_head_r <= '0;
      cur_id_r <= '0;
      cur_level_r <= '0;
      cur_rem_r <= '0;
      cur_from_rr_r <= 1'b0;
      quantum_left_r <= '0;
      busy_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prio_count_r <= prio_count_nxt;
      rr_count_r <= rr_count_nxt;
      rr_head_r <= rr_head_nxt;
      cur_id_r <= cur_id_nxt;
      cur_level_r <= cur_level_nxt;
      cur_rem_r <= cur_rem_nxt;
      cur_from_rr_r <= cur_from_rr_nxt;
      quantum_left_r <= quantum_left_nxt;
      busy_r <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    in_id_r <= in_id_nxt;
    in_prio_r <= in_prio_nxt;
    in_burst_r <= in_burst_nxt;
    if (do_emit) begin
      out_data_r <= {em_status, em_id, em_from2, em_fin,
                     5'(prio_count_nxt), 5'(rr_count_nxt)};
    end
  end

  `MQS_ASSERT_IMP(a_slots, clk, rst_n, 1'b1,
    (prio_count_r + rr_count_r + CW'(busy_r)) <= DEPTH_C, "job slots exceeded")
  `MQS_ASSERT_IMP(a_emit_free, clk, rst_n, do_emit, !out_valid_r || out_ch.ready,
    "result overwrites pending transaction")
  `MQS_ASSERT_NXT(a_run_busy, clk, rst_n, state_r == S_IDLE && !in_acc,
    $stable(busy_r), "busy changed while idle")
  `MQS_ASSERT_IMP(a_run_has_job, clk, rst_n, state_r == S_RUN, busy_r,
    "ran with no job")
endmodule

// ===== sv/mqs_ram.sv =====
// ----------------------------------------------------------------------------
// mqs_ram
// single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mqs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
